>>> hw/rtl/lcas_pkg.sv
`timescale 1ns / 1ps
package lcas_pkg;

   localparam int ROW_W    = 64;
   localparam int IDX_W    = 10;
   localparam int CNT_W    = 11;
   localparam int NCOL_W   = 7;
   localparam int CSR_A_W  = 8;
   localparam int CSR_D_W  = 11;

   localparam logic [NCOL_W-1:0] MAX_COLS = 7'd64;
   localparam logic [CNT_W-1:0]  MAX_ROWS = 11'd1024;

   localparam logic [CNT_W-1:0]  NUM_ROWS_RESET = 11'd20;
   localparam logic [NCOL_W-1:0] NUM_COLS_RESET = 7'd50;

   localparam logic [CSR_A_W-1:0] CSR_NUM_ROWS = 8'd0;
   localparam logic [CSR_A_W-1:0] CSR_NUM_COLS = 8'd1;

   // one row to evolve, with its neighbors already masked
   typedef struct packed {
      logic [ROW_W-1:0] row_above;
      logic [ROW_W-1:0] row_mid;
      logic [ROW_W-1:0] row_below;
      logic [ROW_W-1:0] col_mask;
      logic [IDX_W-1:0] row_index;
      logic             frame_done;
   } lcas_job_type;

   // B3/S23 over one row, columns outside the grid dead
   function automatic logic [ROW_W-1:0] life_row(input logic [ROW_W-1:0] a,
                                                 input logic [ROW_W-1:0] b,
                                                 input logic [ROW_W-1:0] c,
                                                 input logic [ROW_W-1:0] m);
      logic [ROW_W+1:0] ea;
      logic [ROW_W+1:0] eb;
      logic [ROW_W+1:0] ec;
      logic [3:0]       cnt;
      logic [ROW_W-1:0] res;
      ea  = {1'b0, a & m, 1'b0};
      eb  = {1'b0, b & m, 1'b0};
      ec  = {1'b0, c & m, 1'b0};
      res = '0;
      for (int j = 0; j < ROW_W; j++) begin
         cnt = 4'(ea[j]) + 4'(ea[j+1]) + 4'(ea[j+2])
             + 4'(ec[j]) + 4'(ec[j+1]) + 4'(ec[j+2])
             + 4'(eb[j]) + 4'(eb[j+2]);
         if (eb[j+1]) begin
            res[j] = (cnt == 4'd2) || (cnt == 4'd3);
         end else begin
            res[j] = (cnt == 4'd3);
         end
      end
      return res & m;
   endfunction

endpackage

>>> hw/rtl/lcas_if.sv
`timescale 1ns / 1ps
interface lcas_req_if;
   logic                      valid;
   logic                      ready;
   logic [lcas_pkg::ROW_W-1:0] row_cells;
   modport source (output valid, output row_cells, input ready);
   modport sink (input valid, input row_cells, output ready);
endinterface

interface lcas_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lcas_pkg::IDX_W-1:0] row_index;
   logic [lcas_pkg::ROW_W-1:0] next_cells;
   logic                      frame_done;
   modport source (output valid, output row_index, output next_cells, output frame_done,
                   input ready);
   modport sink (input valid, input row_index, input next_cells, input frame_done,
                 output ready);
endinterface

interface lcas_csr_if;
   logic                        valid;
   logic                        ready;
   logic [lcas_pkg::CSR_A_W-1:0] addr;
   logic [lcas_pkg::CSR_D_W-1:0] data;
   modport source (output valid, output addr, output data, input ready);
   modport sink (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/lcas_front.sv
`timescale 1ns / 1ps
module lcas_front (
   input  logic                       clock,
   input  logic                       reset,
   lcas_req_if.sink                   req_bus,
   lcas_csr_if.sink                   csr_bus,
   input  logic                       queue_full,
   output logic                       push,
   output lcas_pkg::lcas_job_type     push_job
);
   import lcas_pkg::*;

   logic [CNT_W-1:0]  num_rows_ff, num_rows_in;
   logic [NCOL_W-1:0] num_cols_ff, num_cols_in;
   logic [ROW_W-1:0]  upper_ff, upper_in;
   logic [ROW_W-1:0]  middle_ff, middle_in;
   logic [CNT_W-1:0]  rows_seen_ff, rows_seen_in;
   logic              pend_valid_ff, pend_valid_in;
   lcas_job_type      pend_job_ff, pend_job_in;

   logic [CNT_W-1:0]  rows_eff;
   logic [NCOL_W-1:0] cols_eff;
   logic [ROW_W-1:0]  mask;
   logic [ROW_W-1:0]  cur;
   logic              have_prev;
   logic              last;
   logic              accept;
   lcas_job_type      job_mid;
   lcas_job_type      job_last;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = !pend_valid_ff && !queue_full;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      priority if (num_rows_ff == '0) begin
         rows_eff = CNT_W'(1);
      end else if (num_rows_ff > MAX_ROWS) begin
         rows_eff = MAX_ROWS;
      end else begin
         rows_eff = num_rows_ff;
      end
      priority if (num_cols_ff == '0) begin
         cols_eff = NCOL_W'(1);
      end else if (num_cols_ff > MAX_COLS) begin
         cols_eff = MAX_COLS;
      end else begin
         cols_eff = num_cols_ff;
      end
   end

   // shift by 64 clears everything, so a full row yields all ones
   assign mask      = ~({ROW_W{1'b1}} << cols_eff);
   assign cur       = req_bus.row_cells & mask;
   assign have_prev = (rows_seen_ff != '0);
   assign last      = ({1'b0, rows_seen_ff} + (CNT_W+1)'(1)) >= {1'b0, rows_eff};

   always_comb begin
      job_mid.row_above  = upper_ff & mask;
      job_mid.row_mid    = middle_ff & mask;
      job_mid.row_below  = cur;
      job_mid.col_mask   = mask;
      job_mid.row_index  = IDX_W'(rows_seen_ff - CNT_W'(1));
      job_mid.frame_done = 1'b0;

      job_last.row_above  = have_prev ? (middle_ff & mask) : '0;
      job_last.row_mid    = cur;
      job_last.row_below  = '0;
      job_last.col_mask   = mask;
      job_last.row_index  = rows_seen_ff[IDX_W-1:0];
      job_last.frame_done = 1'b1;
   end

   always_comb begin
      num_rows_in   = num_rows_ff;
      num_cols_in   = num_cols_ff;
      upper_in      = upper_ff;
      middle_in     = middle_ff;
      rows_seen_in  = rows_seen_ff;
      pend_valid_in = pend_valid_ff;
      pend_job_in   = pend_job_ff;
      push          = 1'b0;
      push_job      = job_mid;

      if (csr_bus.valid) begin
         if (csr_bus.addr == CSR_NUM_ROWS) begin
            num_rows_in = csr_bus.data;
         end else if (csr_bus.addr == CSR_NUM_COLS) begin
            num_cols_in = csr_bus.data[NCOL_W-1:0];
         end
      end

      if (pend_valid_ff) begin
         push     = !queue_full;
         push_job = pend_job_ff;
         if (!queue_full) begin
            pend_valid_in = 1'b0;
         end
      end else if (accept) begin
         push     = have_prev || last;
         push_job = have_prev ? job_mid : job_last;
         // final row after earlier ones: second result is held in the pending register until the queue has room
         if (last && have_prev) begin
            pend_valid_in = 1'b1;
            pend_job_in   = job_last;
         end
         if (last) begin
            upper_in     = '0;
            middle_in    = '0;
            rows_seen_in = '0;
         end else begin
            upper_in     = have_prev ? middle_ff : '0;
            middle_in    = cur;
            rows_seen_in = rows_seen_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_rows_ff   <= NUM_ROWS_RESET;
         num_cols_ff   <= NUM_COLS_RESET;
         upper_ff      <= '0;
         middle_ff     <= '0;
         rows_seen_ff  <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         num_rows_ff   <= num_rows_in;
         num_cols_ff   <= num_cols_in;
         upper_ff      <= upper_in;
         middle_ff     <= middle_in;
         rows_seen_ff  <= rows_seen_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_job_ff <= pend_job_in;
   end

   a_pend_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(pend_valid_ff) |-> $past(accept && last && have_prev))
      else $error("pending final row without a final request");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && last) |=> (rows_seen_ff == '0) && (middle_ff == '0))
      else $error("row state not cleared after final row");

endmodule

>>> hw/rtl/lcas_queue.sv
`timescale 1ns / 1ps
module lcas_queue #(
   parameter int DEPTH = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  lcas_pkg::lcas_job_type push_job,
   output logic                   full,
   input  logic                   pop,
   output lcas_pkg::lcas_job_type head_job,
   output logic                   empty
);
   import lcas_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_QW = $clog2(DEPTH + 1);

   lcas_job_type      slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_QW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_QW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_QW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("pop from empty queue");

endmodule

>>> hw/rtl/lcas_back.sv
`timescale 1ns / 1ps
module lcas_back (
   input  logic                   clock,
   input  logic                   reset,
   input  lcas_pkg::lcas_job_type head_job,
   input  logic                   empty,
   output logic                   pop,
   lcas_rsp_if.source             rsp_bus
);
   import lcas_pkg::*;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] row_index_ff;
   logic [ROW_W-1:0] next_cells_ff;
   logic             frame_done_ff;
   logic [ROW_W-1:0] next_cells;

   assign next_cells = life_row(head_job.row_above, head_job.row_mid,
                                head_job.row_below, head_job.col_mask);

   assign pop          = !empty && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_valid_in = pop || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         row_index_ff  <= head_job.row_index;
         next_cells_ff <= next_cells;
         frame_done_ff <= head_job.frame_done;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.row_index  = row_index_ff;
   assign rsp_bus.next_cells = next_cells_ff;
   assign rsp_bus.frame_done = frame_done_ff;

   a_pop_loads_output: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped row not presented");

endmodule

>>> hw/rtl/life_cellular_automaton_step_top.sv
`timescale 1ns / 1ps
// channel   dir  handshake      payload
// req_bus   in   valid/ready    row_cells[63:0]
// rsp_bus   out  valid/ready    row_index[9:0], next_cells[63:0], frame_done
// csr_bus   in   valid/ready    addr[7:0] (0 num_rows, 1 num_cols), data[10:0]
//
// One row request per cycle while req ready is high; each request after the first of a frame yields the row above it.
// A final row after earlier rows yields two responses and holds req ready low until the second job enters the queue.
// Each job passes through the job queue, then the output register.
// A stalled response backs up the queue of QUEUE_DEPTH jobs, then req ready drops.
// Synchronous reset; num_rows resets to 20 and num_cols to 50; csr ready is always high.
module life_cellular_automaton_step_top #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic  clock,
   input  logic  reset,
   lcas_req_if.sink   req_bus,
   lcas_rsp_if.source rsp_bus,
   lcas_csr_if.sink   csr_bus
);
   import lcas_pkg::*;

   logic         queue_full;
   logic         queue_empty;
   logic         push;
   logic         pop;
   lcas_job_type push_job;
   lcas_job_type head_job;

   lcas_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .csr_bus    (csr_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   lcas_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (queue_full),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty)
   );

   lcas_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_job (head_job),
      .empty    (queue_empty),
      .pop      (pop),
      .rsp_bus  (rsp_bus)
   );

endmodule
